FILE: rtl/pmprg_pkg.sv
// ----------------------------------------------------------------------------
// pmprg_pkg: shared types and constants for the PMP region encode/decode block
// Operation and status codes, address-mode bits, and the command bundle
// that the controller drives into the datapath.
// ----------------------------------------------------------------------------
package pmprg_pkg;

	// operation codes carried in the request op field
	localparam logic OP_SET = 1'b0;
	localparam logic OP_GET = 1'b1;

	// response status codes
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	// address-mode field of the configuration byte (bits 4..3)
	localparam logic [7:0] MODE_MASK  = 8'h18;
	localparam logic [7:0] MODE_NA4   = 8'h10;
	localparam logic [7:0] MODE_NAPOT = 8'h18;

	// address granularity: stored word is the byte address shifted right by 2
	localparam int unsigned GRAN_SHIFT = 2;

	// payload widths fixed by the request and response formats
	localparam int unsigned IDX_BITS  = 4;
	localparam int unsigned PROT_BITS = 8;
	localparam int unsigned ADDR_BITS = 64;
	localparam int unsigned LOG2_BITS = 7;

	// controller to datapath commands
	typedef struct packed {
		logic capture;   // latch the accepted request
		logic access;    // write the entry on a set, read it on a get
		logic load_out;  // load the response register
	} pmprg_cmd_t;

endpackage

FILE: rtl/pmprg_if.sv
// ----------------------------------------------------------------------------
// pmprg_req_if / pmprg_rsp_if: request and response channels
// Valid/ready channels; a transaction completes on a rising edge of clk
// where valid and ready are both high.
// ----------------------------------------------------------------------------
interface pmprg_req_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 op;
	logic [pmprg_pkg::IDX_BITS-1:0]       entry_index;
	logic [pmprg_pkg::PROT_BITS-1:0]      prot_bits;
	logic [pmprg_pkg::ADDR_BITS-1:0]      region_addr;
	logic [pmprg_pkg::LOG2_BITS-1:0]      region_log2;

	modport source (
		output valid, op, entry_index, prot_bits, region_addr, region_log2,
		input  ready
	);
	modport sink (
		input  valid, op, entry_index, prot_bits, region_addr, region_log2,
		output ready
	);
endinterface

interface pmprg_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 status;
	logic [pmprg_pkg::PROT_BITS-1:0]      entry_prot;
	logic [pmprg_pkg::ADDR_BITS-1:0]      base_addr;
	logic [pmprg_pkg::LOG2_BITS-1:0]      log2_out;

	modport source (
		output valid, status, entry_prot, base_addr, log2_out,
		input  ready
	);
	modport sink (
		input  valid, status, entry_prot, base_addr, log2_out,
		output ready
	);
endinterface

FILE: rtl/pmprg_ctrl.sv
// ----------------------------------------------------------------------------
// pmprg_ctrl: request sequencer
// Steps each transaction through capture, entry access and response load,
// and owns the response valid flag.
// ----------------------------------------------------------------------------
module pmprg_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pmprg_pkg::pmprg_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_DEC  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	// commands
	assign in_ready     = (state_q == ST_IDLE);
	assign cmd.capture  = in_valid && in_ready;
	assign cmd.access   = (state_q == ST_RD);
	assign cmd.load_out = (state_q == ST_DEC) && (!out_valid_q || out_ready);
	assign out_valid    = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.capture) state_d = ST_RD;
			end
			ST_RD: begin
				state_d = ST_DEC;
			end
			ST_DEC: begin
				if (cmd.load_out) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	// an accepted request always goes to the entry access next
	a_accept_to_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_RD))
		else $error("accepted request did not start entry access");

	// access lasts one cycle and is followed by decode
	a_rd_to_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |=> (state_q == ST_DEC))
		else $error("entry access not followed by decode");

	// a response is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("response register overwritten");

	// no new request while one is in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("request accepted while busy");
`endif

endmodule

FILE: rtl/pmprg_datapath.sv
// ----------------------------------------------------------------------------
// pmprg_datapath: entry store, region encoder and decoder
// Holds the configuration byte and address word of each entry, encodes
// a set into NA4/NAPOT form, decodes a get back to base and log2 size,
// and registers the response.
// ----------------------------------------------------------------------------
module pmprg_datapath #(
	parameter int unsigned ENTRIES = 16,
	parameter int unsigned XLEN    = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pmprg_pkg::pmprg_cmd_t                 cmd,
	input  logic                                  op,
	input  logic [pmprg_pkg::IDX_BITS-1:0]        entry_index,
	input  logic [pmprg_pkg::PROT_BITS-1:0]       prot_bits,
	input  logic [pmprg_pkg::ADDR_BITS-1:0]       region_addr,
	input  logic [pmprg_pkg::LOG2_BITS-1:0]       region_log2,
	output logic                                  status,
	output logic [pmprg_pkg::PROT_BITS-1:0]       entry_prot,
	output logic [pmprg_pkg::ADDR_BITS-1:0]       base_addr,
	output logic [pmprg_pkg::LOG2_BITS-1:0]       log2_out
);

	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned AW    = pmprg_pkg::ADDR_BITS;
	localparam int unsigned LW    = pmprg_pkg::LOG2_BITS;
	localparam int unsigned PW    = pmprg_pkg::PROT_BITS;

	// index of the set bit of a one-hot word
	function automatic logic [LW-1:0] onehot_idx(input logic [AW-1:0] oh);
		logic [LW-1:0] r;
		r = '0;
		for (int i = 0; i < AW; i++) begin
			if (oh[i]) r = r | LW'(i);
		end
		return r;
	endfunction

	// captured request
	logic                                  op_q;
	logic [pmprg_pkg::IDX_BITS-1:0]        idx_q;
	logic [PW-1:0]                         prot_q;
	logic [AW-1:0]                         addr_q;
	logic [LW-1:0]                         l2_q;

	// entry store
	logic [PW-1:0]   mem_cfg  [ENTRIES];
	logic [XLEN-1:0] mem_addr [ENTRIES];
	logic [ENTRIES-1:0] vld_q;

	// registered read data
	logic [PW-1:0]   rd_cfg_s1;
	logic [XLEN-1:0] rd_addr_s1;
	logic            rd_vld_s1;

	// response register
	logic            status_q;
	logic [PW-1:0]   entry_prot_q;
	logic [AW-1:0]   base_addr_q;
	logic [LW-1:0]   log2_out_q;

	logic [IDX_W-1:0] widx;
	logic             idx_ok;
	logic             size_ok;
	logic             wr_en;

	// encode signals
	logic            is_na4;
	logic            is_full;
	logic [5:0]      sh;
	logic [AW-1:0]   addr_sh;
	logic [AW-1:0]   m;
	logic [AW-1:0]   word64;
	logic [XLEN-1:0] enc_word;
	logic [PW-1:0]   enc_cfg;

	// decode signals
	logic [PW-1:0]   cfg_d;
	logic [XLEN-1:0] word_d;
	logic [XLEN-1:0] plus1;
	logic [XLEN-1:0] low;
	logic [XLEN-1:0] lowz;
	logic            napot;
	logic            all_ones;
	logic [AW-1:0]   base_d;
	logic [LW-1:0]   size_d;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op;
			idx_q  <= entry_index;
			prot_q <= prot_bits;
			addr_q <= region_addr;
			l2_q   <= region_log2;
		end
	end

	// argument checks
	assign widx    = IDX_W'(idx_q);
	assign idx_ok  = (LW'(idx_q) < LW'(ENTRIES));
	assign size_ok = (l2_q >= LW'(pmprg_pkg::GRAN_SHIFT)) && (l2_q <= LW'(XLEN));

	// region encode: shifted base, with trailing ones marking the size in NAPOT form
	assign is_na4   = (l2_q == LW'(pmprg_pkg::GRAN_SHIFT));
	assign is_full  = (l2_q == LW'(XLEN));
	assign sh       = 6'(l2_q - LW'(pmprg_pkg::GRAN_SHIFT));
	assign addr_sh  = addr_q >> pmprg_pkg::GRAN_SHIFT;
	assign m        = ~({AW{1'b1}} << sh);
	assign word64   = is_na4 ? addr_sh : ((addr_sh & ~m) | (m >> 1));
	assign enc_word = is_full ? {XLEN{1'b1}} : word64[XLEN-1:0];
	assign enc_cfg  = prot_q | (is_na4 ? pmprg_pkg::MODE_NA4 : pmprg_pkg::MODE_NAPOT);

	assign wr_en = cmd.access && (op_q == pmprg_pkg::OP_SET) && idx_ok && size_ok;

	// entry store write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_cfg[widx]  <= enc_cfg;
			mem_addr[widx] <= enc_word;
		end
		if (cmd.access) begin
			rd_cfg_s1  <= mem_cfg[widx];
			rd_addr_s1 <= mem_addr[widx];
			rd_vld_s1  <= vld_q[widx];
		end
	end

	// entries read as zero until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[widx] <= 1'b1;
		end
	end

	// region decode
	assign cfg_d    = rd_vld_s1 ? rd_cfg_s1 : '0;
	assign word_d   = rd_vld_s1 ? rd_addr_s1 : '0;
	assign napot    = ((cfg_d & pmprg_pkg::MODE_MASK) == pmprg_pkg::MODE_NAPOT);
	assign all_ones = &word_d;
	assign plus1    = word_d + XLEN'(1);
	assign low      = word_d & ~plus1;
	assign lowz     = ~word_d & plus1;

	always_comb begin
		if (napot && all_ones) begin
			base_d = '0;
			size_d = LW'(XLEN);
		end else if (napot) begin
			base_d = AW'(word_d & ~low) << pmprg_pkg::GRAN_SHIFT;
			size_d = onehot_idx(AW'(lowz)) + LW'(pmprg_pkg::GRAN_SHIFT + 1);
		end else begin
			base_d = AW'(word_d) << pmprg_pkg::GRAN_SHIFT;
			size_d = LW'(pmprg_pkg::GRAN_SHIFT);
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status_q     <= pmprg_pkg::STATUS_OK;
			entry_prot_q <= '0;
			base_addr_q  <= '0;
			log2_out_q   <= '0;
			if (!idx_ok) begin
				status_q <= pmprg_pkg::STATUS_BAD;
			end else if (op_q == pmprg_pkg::OP_SET) begin
				status_q <= size_ok ? pmprg_pkg::STATUS_OK : pmprg_pkg::STATUS_BAD;
			end else begin
				entry_prot_q <= cfg_d;
				base_addr_q  <= base_d;
				log2_out_q   <= size_d;
			end
		end
	end

	assign status     = status_q;
	assign entry_prot = entry_prot_q;
	assign base_addr  = base_addr_q;
	assign log2_out   = log2_out_q;

endmodule

FILE: rtl/pmp_region_encode_decode_top.sv
// ----------------------------------------------------------------------------
// pmp_region_encode_decode_top: PMP region encode/decode block
// Set and get requests on a table of protection entries, NA4/NAPOT form.
// ----------------------------------------------------------------------------
// A request transaction is accepted only while the block is idle. The cycle
// after acceptance accesses the entry store (registered read, or the write of
// a set) and the decode step after that loads the response register. The
// next request is taken in the cycle after the response is loaded, even
// while the previous response still waits in the response register, but
// its decode step then holds until that response is taken. A set returns
// status only; a get returns the stored byte, the decoded base and the log2
// size. An index at or above ENTRIES, or a set size outside 2..XLEN, returns
// status 1 and leaves the table untouched. The table reads as all zero after
// reset through per-entry valid flags; no clearing pass is run.
module pmp_region_encode_decode_top #(
	parameter int unsigned ENTRIES = 16,
	parameter int unsigned XLEN    = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	pmprg_req_if.sink   req,
	pmprg_rsp_if.source rsp
);

	pmprg_pkg::pmprg_cmd_t cmd;

	// sequencer
	pmprg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	// entry store and encode/decode
	pmprg_datapath #(
		.ENTRIES (ENTRIES),
		.XLEN    (XLEN)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.op          (req.op),
		.entry_index (req.entry_index),
		.prot_bits   (req.prot_bits),
		.region_addr (req.region_addr),
		.region_log2 (req.region_log2),
		.status      (rsp.status),
		.entry_prot  (rsp.entry_prot),
		.base_addr   (rsp.base_addr),
		.log2_out    (rsp.log2_out)
	);

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for pmp_region_encode_decode_top
// Drives set and get transactions on the request channel and predicts each
// response from a local copy of the entry table. Responses are compared
// field by field in order. Covers the size limits, the NA4 and NAPOT
// encodings, the whole-space entry and reads of entries never written.
// Stimulus runs through phases of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned ENTRY_COUNT = 16;
	localparam int unsigned XLEN_W      = 64;
	localparam int unsigned IDX_W       = pmprg_pkg::IDX_BITS;
	localparam int unsigned PROT_W      = pmprg_pkg::PROT_BITS;
	localparam int unsigned ADDR_W      = pmprg_pkg::ADDR_BITS;
	localparam int unsigned L2_W        = pmprg_pkg::LOG2_BITS;
	localparam logic [XLEN_W-1:0] ALL_ONES = '1;

	typedef struct packed {
		logic              op;
		logic [IDX_W-1:0]  idx;
		logic [PROT_W-1:0] prot;
		logic [ADDR_W-1:0] addr;
		logic [L2_W-1:0]   l2;
	} pmp_req_t;

	typedef struct packed {
		logic              status;
		logic [PROT_W-1:0] prot;
		logic [ADDR_W-1:0] addr;
		logic [L2_W-1:0]   l2;
	} pmp_rsp_t;

	logic clk;
	logic arst_n;

	pmprg_req_if req ();
	pmprg_rsp_if rsp ();

	pmp_region_encode_decode_top #(
		.ENTRIES (ENTRY_COUNT),
		.XLEN    (XLEN_W)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// shadow of the protection entry table
	logic [PROT_W-1:0] entry_cfg_shadow  [ENTRY_COUNT];
	logic [XLEN_W-1:0] entry_word_shadow [ENTRY_COUNT];

	pmp_req_t pending_req[$];
	pmp_rsp_t expected_rsp[$];

	int   mismatch_count = 0;
	int   send_idle_pct  = 0;
	int   rsp_stall_pct  = 0;
	logic req_taken;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("tb: mismatch %s got %0h want %0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// apply one request to the shadow table and return the response it gives
	function automatic pmp_rsp_t pmp_apply(input pmp_req_t r);
		pmp_rsp_t          res;
		logic [XLEN_W-1:0] w;
		logic [XLEN_W-1:0] m;
		logic [PROT_W-1:0] cfg;
		int unsigned       t;
		res = '0;
		res.status = pmprg_pkg::STATUS_OK;
		if (r.idx >= ENTRY_COUNT) begin
			res.status = pmprg_pkg::STATUS_BAD;
		end else if (r.op == pmprg_pkg::OP_SET) begin
			if (r.l2 < pmprg_pkg::GRAN_SHIFT || r.l2 > XLEN_W) begin
				res.status = pmprg_pkg::STATUS_BAD;
			end else begin
				if (r.l2 == pmprg_pkg::GRAN_SHIFT) begin
					cfg = r.prot | pmprg_pkg::MODE_NA4;
					w = r.addr >> pmprg_pkg::GRAN_SHIFT;
				end else if (r.l2 == XLEN_W) begin
					cfg = r.prot | pmprg_pkg::MODE_NAPOT;
					w = ALL_ONES;
				end else begin
					cfg = r.prot | pmprg_pkg::MODE_NAPOT;
					m = (64'd1 << (r.l2 - pmprg_pkg::GRAN_SHIFT)) - 64'd1;
					w = ((r.addr >> pmprg_pkg::GRAN_SHIFT) & ~m) | (m >> 1);
				end
				entry_cfg_shadow[r.idx]  = cfg;
				entry_word_shadow[r.idx] = w;
			end
		end else begin
			cfg = entry_cfg_shadow[r.idx];
			w   = entry_word_shadow[r.idx];
			res.prot = cfg;
			if ((cfg & pmprg_pkg::MODE_MASK) == pmprg_pkg::MODE_NAPOT) begin
				if (w == ALL_ONES) begin
					res.addr = '0;
					res.l2   = L2_W'(XLEN_W);
				end else begin
					// trailing ones give the size, the rest is the base
					t = 0;
					while (t < XLEN_W && w[t])
						t++;
					m = (64'd1 << t) - 64'd1;
					res.addr = (w & ~m) << pmprg_pkg::GRAN_SHIFT;
					res.l2   = L2_W'(t + pmprg_pkg::GRAN_SHIFT + 1);
				end
			end else begin
				// off or NA4: plain shifted word, granule size
				res.addr = w << pmprg_pkg::GRAN_SHIFT;
				res.l2   = L2_W'(pmprg_pkg::GRAN_SHIFT);
			end
		end
		return res;
	endfunction

	task automatic push_set(input int idx, input logic [7:0] prot,
		input logic [63:0] addr, input int l2);
		pmp_req_t r;
		r.op   = pmprg_pkg::OP_SET;
		r.idx  = IDX_W'(idx);
		r.prot = prot;
		r.addr = addr;
		r.l2   = L2_W'(l2);
		pending_req.push_back(r);
	endtask

	task automatic push_get(input int idx);
		pmp_req_t r;
		r.op   = pmprg_pkg::OP_GET;
		r.idx  = IDX_W'(idx);
		r.prot = PROT_W'($urandom_range(255));
		r.addr = {$urandom, $urandom};
		r.l2   = L2_W'($urandom_range(127));
		pending_req.push_back(r);
	endtask

	// random transaction: mostly valid sets and gets, some bad sizes
	task automatic push_random();
		int sel;
		int l2;
		sel = $urandom_range(99);
		if (sel < 48) begin
			case ($urandom_range(9))
				0: l2 = pmprg_pkg::GRAN_SHIFT;
				1: l2 = XLEN_W;
				default: l2 = $urandom_range(XLEN_W - 1, pmprg_pkg::GRAN_SHIFT + 1);
			endcase
			push_set($urandom_range(ENTRY_COUNT - 1), PROT_W'($urandom_range(255)),
				{$urandom, $urandom}, l2);
		end else if (sel < 58) begin
			l2 = $urandom_range(1) ? $urandom_range(pmprg_pkg::GRAN_SHIFT - 1)
				: $urandom_range(127, XLEN_W + 1);
			push_set($urandom_range(ENTRY_COUNT - 1), PROT_W'($urandom_range(255)),
				{$urandom, $urandom}, l2);
		end else begin
			push_get($urandom_range(ENTRY_COUNT - 1));
		end
	endtask

	// request driver: new transaction at the falling edge once the last was taken
	always @(negedge clk) begin : drive_req
		pmp_req_t nxt;
		if (arst_n && (!req.valid || req_taken)) begin
			if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pending_req.pop_front();
				req.valid       <= 1'b1;
				req.op          <= nxt.op;
				req.entry_index <= nxt.idx;
				req.prot_bits   <= nxt.prot;
				req.region_addr <= nxt.addr;
				req.region_log2 <= nxt.l2;
			end else begin
				req.valid <= 1'b0;
			end
		end
		if (arst_n)
			rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	// monitor: check responses, predict accepted requests
	always @(posedge clk or negedge arst_n) begin : watch
		pmp_req_t r;
		pmp_rsp_t want;
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= req.valid && req.ready;
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp.size() == 0) begin
					report_mismatch("unexpected response status", 64'(rsp.status), '0);
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", 64'(rsp.status), 64'(want.status));
					if (rsp.entry_prot !== want.prot)
						report_mismatch("entry_prot", 64'(rsp.entry_prot), 64'(want.prot));
					if (rsp.base_addr !== want.addr)
						report_mismatch("base_addr", rsp.base_addr, want.addr);
					if (rsp.log2_out !== want.l2)
						report_mismatch("log2_out", 64'(rsp.log2_out), 64'(want.l2));
				end
			end
			if (req.valid && req.ready) begin
				r.op   = req.op;
				r.idx  = req.entry_index;
				r.prot = req.prot_bits;
				r.addr = req.region_addr;
				r.l2   = req.region_log2;
				expected_rsp.push_back(pmp_apply(r));
			end
		end
	end

	// stimulus and sequencing
	initial begin : main
		int send_pct [4];
		int stall_pct[4];
		send_pct  = '{0, 87, 0, 21};
		stall_pct = '{0, 0, 87, 21};
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			entry_cfg_shadow[i]  = '0;
			entry_word_shadow[i] = '0;
		end
		arst_n          = 1'b0;
		req.valid       = 1'b0;
		req.op          = pmprg_pkg::OP_SET;
		req.entry_index = '0;
		req.prot_bits   = '0;
		req.region_addr = '0;
		req.region_log2 = '0;
		rsp.ready       = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: unwritten entry, size limits, NA4, NAPOT, whole space
		push_get(5);
		push_set(0, 8'h00, ALL_ONES, 0);
		push_set(0, 8'hff, 64'h0, 1);
		push_get(0);
		push_set(1, 8'h00, ALL_ONES, pmprg_pkg::GRAN_SHIFT);
		push_get(1);
		// NA4 request with the low mode bit already set turns into NAPOT
		push_set(2, 8'h08, 64'h1234_5678_9abc_def4, pmprg_pkg::GRAN_SHIFT);
		push_get(2);
		push_set(3, 8'hff, ALL_ONES, 3);
		push_get(3);
		push_set(4, 8'h07, 64'h8000_0000_0000_0000, 63);
		push_get(4);
		push_set(5, 8'h80, {$urandom, $urandom}, XLEN_W);
		push_get(5);
		push_set(6, 8'h01, ALL_ONES, XLEN_W + 1);
		push_set(6, 8'h01, ALL_ONES, 127);
		push_get(6);
		push_set(15, 8'h03, ALL_ONES, 62);
		push_get(15);
		push_set(15, 8'he7, ALL_ONES, pmprg_pkg::GRAN_SHIFT);
		push_get(15);
		push_set(7, 8'h00, 64'h0, 32);
		push_get(7);

		// random phases with different idle and stall pressure
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = send_pct[p];
			rsp_stall_pct = stall_pct[p];
			for (int n = 0; n < 107; n++)
				push_random();
			wait (pending_req.size() == 0);
			@(posedge clk);
		end

		// drain
		wait (!req.valid);
		wait (expected_rsp.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
